// File: rtl/core/frame_time_scale_governor_unit_defines.svh
// Assertion macros for the frame time scale governor checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FRAME_TIME_SCALE_GOVERNOR_UNIT_DEFINES_SVH
`define FRAME_TIME_SCALE_GOVERNOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTSG_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FTSG_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ftsg_pkg.sv
// Shared types and constants of the frame time scale governor.
// No dependencies; used by the interfaces, the top level and the checker.
package ftsg_pkg;

	// field widths
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned SMOOTH_W   = 24;
	localparam int unsigned RUN_W      = 8;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [SMOOTH_W-1:0] smooth_t;
	typedef logic [RUN_W-1:0]    run_t;
	typedef logic [PCT_W-1:0]    pct_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BUDGET     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_RUN_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_RUN_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FLOOR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_STEP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP        = 3'd5;

	// register reset values
	localparam time_t RST_FRAME_BUDGET     = 16'd4267;
	localparam run_t  RST_OVER_RUN_LENGTH  = 8'd5;
	localparam run_t  RST_UNDER_RUN_LENGTH = 8'd30;
	localparam pct_t  RST_SCALE_FLOOR      = 7'd75;
	localparam pct_t  RST_DROP_STEP        = 7'd10;
	localparam pct_t  RST_RISE_STEP        = 7'd5;

	// scale limits
	localparam pct_t SCALE_MAX     = 7'd100;
	localparam pct_t UPSCALE_LIMIT = 7'd98;
	localparam run_t RUN_SAT       = 8'hFF;

	// floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for every n below 2^30
	localparam int unsigned NUM_W         = 28;
	localparam int unsigned RECIP10_SHIFT = 31;
	localparam logic [NUM_W-1:0] RECIP10  = 28'd214748365;

endpackage

// File: rtl/core/ftsg_in_if.sv
// Input channel of the frame time scale governor: one frame time per item.
// Depends on ftsg_pkg.
interface ftsg_in_if import ftsg_pkg::*;;
	logic  valid;
	logic  ready;
	time_t frame_time;

	modport source (output valid, output frame_time, input ready);
	modport sink   (input valid, input frame_time, output ready);
endinterface

// File: rtl/core/ftsg_out_if.sv
// Result channel of the frame time scale governor: scale, flag and average.
// Depends on ftsg_pkg.
interface ftsg_out_if import ftsg_pkg::*;;
	logic  valid;
	logic  ready;
	pct_t  scale_percent;
	logic  upscaling_active;
	time_t average_time;

	modport source (output valid, output scale_percent, output upscaling_active,
		output average_time, input ready);
	modport sink   (input valid, input scale_percent, input upscaling_active,
		input average_time, output ready);
endinterface

// File: rtl/core/frame_time_scale_governor_unit.sv
// Frame time scale governor: averages frame times and steps a render scale.
// Depends on ftsg_pkg, ftsg_in_if and ftsg_out_if.
//
//  port        direction  payload
//  ----------  ---------  ---------------------------------------------------
//  frame_in    sink       frame_time (Q8.8 ms)
//  result_out  source     scale_percent, upscaling_active, average_time
//  cfg_*       write      cfg_index selects the register, cfg_wdata its value
//
// One item per cycle while result_out is not stalled; an accepted item passes
// valid_s1 and then the result register valid_s2 before its result is valid.
// Stage 1 updates the average (multiply-by-reciprocal divide by ten, the
// loop through the average register); stage 2 compares against the budget and
// steps the run counters and the scale, writing the result register.
// A stalled result holds stage 2; stage 1 still takes an item while empty.
// Reset or a frame_budget write restores average, scale and run counters.
module frame_time_scale_governor_unit import ftsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ftsg_in_if.sink               frame_in,
	ftsg_out_if.source            result_out
);

	localparam smooth_t RST_SMOOTH = {RST_FRAME_BUDGET, 8'd0};

	// configuration registers
	time_t budget_q;
	run_t  over_len_q;
	run_t  under_len_q;
	pct_t  floor_q;
	pct_t  drop_q;
	pct_t  rise_q;

	// governor state
	smooth_t smooth_q;
	pct_t    scale_q;
	run_t    over_q;
	run_t    under_q;

	// pipeline
	logic  valid_s1;
	logic  valid_s2;
	pct_t  scale_s2;
	logic  up_s2;
	time_t avg_s2;

	logic en1;
	logic en2;
	logic accept;
	logic budget_wr;

	logic [NUM_W-1:0]   num;
	logic [2*NUM_W-1:0] prod;
	smooth_t            avg_next;

	logic [NUM_W-1:0]   avg10;
	logic [19:0]        bud11;
	logic [20:0]        bud17;
	logic               over_hit;
	logic               under_hit;

	run_t               over_inc;
	run_t               under_inc;
	logic [PCT_W:0]     drop_diff;
	logic [PCT_W:0]     drop_lim;
	logic [PCT_W:0]     rise_sum;
	pct_t               drop_scale;
	pct_t               rise_scale;
	pct_t               scale_n;
	run_t               over_n;
	run_t               under_n;

	// handshake: stage 2 moves when the result register is free or drained
	assign en2              = !valid_s2 || result_out.ready;
	assign en1              = !valid_s1 || en2;
	assign frame_in.ready   = en1;
	assign accept           = frame_in.valid && en1;
	assign budget_wr        = cfg_we && (cfg_index == REG_FRAME_BUDGET);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= RST_FRAME_BUDGET;
			over_len_q  <= RST_OVER_RUN_LENGTH;
			under_len_q <= RST_UNDER_RUN_LENGTH;
			floor_q     <= RST_SCALE_FLOOR;
			drop_q      <= RST_DROP_STEP;
			rise_q      <= RST_RISE_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_BUDGET:     budget_q    <= cfg_wdata;
				REG_OVER_RUN_LENGTH:  over_len_q  <= cfg_wdata[RUN_W-1:0];
				REG_UNDER_RUN_LENGTH: under_len_q <= cfg_wdata[RUN_W-1:0];
				REG_SCALE_FLOOR:      floor_q     <= cfg_wdata[PCT_W-1:0];
				REG_DROP_STEP:        drop_q      <= cfg_wdata[PCT_W-1:0];
				REG_RISE_STEP:        rise_q      <= cfg_wdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: avg = (9*avg + sample) / 10, divide by reciprocal multiply
	assign num      = {1'b0, smooth_q, 3'b000} + {4'b0000, smooth_q}
	                + {4'b0000, frame_in.frame_time, 8'd0};
	assign prod     = num * RECIP10;
	assign avg_next = prod[RECIP10_SHIFT+SMOOTH_W-1:RECIP10_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= RST_SMOOTH;
		end else if (budget_wr) begin
			smooth_q <= {cfg_wdata, 8'd0};
		end else if (accept) begin
			smooth_q <= avg_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= frame_in.valid;
		end
	end

	// stage 2: budget compares; smooth_q holds the average of the item in stage 1
	assign avg10     = {1'b0, smooth_q, 3'b000} + {3'b000, smooth_q, 1'b0};
	assign bud11     = {1'b0, budget_q, 3'b000} + {3'b000, budget_q, 1'b0}
	                 + {4'b0000, budget_q};
	assign bud17     = {1'b0, budget_q, 4'b0000} + {5'b00000, budget_q};
	assign over_hit  = avg10 > {bud11, 8'd0};
	assign under_hit = {avg10, 1'b0} < {bud17, 8'd0};

	// saturating run counts
	assign over_inc  = (over_q == RUN_SAT) ? over_q : over_q + 8'd1;
	assign under_inc = (under_q == RUN_SAT) ? under_q : under_q + 8'd1;

	// drop: no lower than the floor, no higher than the maximum
	assign drop_diff  = {1'b0, scale_q} - {1'b0, drop_q};
	assign drop_lim   = (drop_diff[PCT_W] || (drop_diff < {1'b0, floor_q}))
	                  ? {1'b0, floor_q} : drop_diff;
	assign drop_scale = (drop_lim > {1'b0, SCALE_MAX}) ? SCALE_MAX : drop_lim[PCT_W-1:0];

	// rise: no higher than the maximum
	assign rise_sum   = {1'b0, scale_q} + {1'b0, rise_q};
	assign rise_scale = (rise_sum > {1'b0, SCALE_MAX}) ? SCALE_MAX : rise_sum[PCT_W-1:0];

	// next governor state for the item in stage 1
	always_comb begin
		scale_n = scale_q;
		over_n  = over_q;
		under_n = under_q;
		if (over_hit) begin
			under_n = '0;
			if (over_inc >= over_len_q) begin
				scale_n = drop_scale;
				over_n  = '0;
			end else begin
				over_n = over_inc;
			end
		end else if (under_hit) begin
			over_n = '0;
			if (under_inc >= under_len_q) begin
				scale_n = rise_scale;
				under_n = '0;
			end else begin
				under_n = under_inc;
			end
		end
	end

	// hold or advance the governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_MAX;
			over_q  <= '0;
			under_q <= '0;
		end else if (budget_wr) begin
			scale_q <= SCALE_MAX;
			over_q  <= '0;
			under_q <= '0;
		end else if (valid_s1 && en2) begin
			scale_q <= scale_n;
			over_q  <= over_n;
			under_q <= under_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			scale_s2 <= scale_n;
			up_s2    <= scale_n <= UPSCALE_LIMIT;
			avg_s2   <= smooth_q[SMOOTH_W-1:SMOOTH_W-TIME_W];
		end
	end

	assign result_out.valid            = valid_s2;
	assign result_out.scale_percent    = scale_s2;
	assign result_out.upscaling_active = up_s2;
	assign result_out.average_time     = avg_s2;

endmodule

// File: rtl/core/ftsg_checker.sv
// Port-level checks of the frame time scale governor, bound to the top level.
// Depends on ftsg_pkg and frame_time_scale_governor_unit_defines.svh.
`include "frame_time_scale_governor_unit_defines.svh"

module ftsg_checker import ftsg_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input pct_t  out_scale,
	input logic  out_up,
	input time_t out_avg
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// a stalled item holds its payload
	`FTSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_scale) && $stable(out_up) && $stable(out_avg), "result changed while stalled")

	// a result appears from an empty output only after an accept
	`FTSG_ASSERT_NOW(a_out_latency, clk, arst_n, $rose(out_valid), $past(in_acc, 2), "result without an item accepted two cycles earlier")

	// the scale never passes its maximum
	`FTSG_ASSERT_NOW(a_scale_range, clk, arst_n, out_valid, out_scale <= SCALE_MAX, "scale above maximum")

	// the upscaling flag follows the scale
	`FTSG_ASSERT_NOW(a_up_flag, clk, arst_n, out_valid, out_up == (out_scale <= UPSCALE_LIMIT), "upscaling flag disagrees with scale")

endmodule

bind frame_time_scale_governor_unit ftsg_checker u_ftsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_scale (result_out.scale_percent),
	.out_up    (result_out.upscaling_active),
	.out_avg   (result_out.average_time)
);
